/* hdl/udpq_pkg.sv */
// Package: request kinds, response status codes and control/status structs.
`default_nettype none
package udpq_pkg;

   localparam logic [1:0] KIND_BIND    = 2'd0;
   localparam logic [1:0] KIND_UNBIND  = 2'd1;
   localparam logic [1:0] KIND_DELIVER = 2'd2;
   localparam logic [1:0] KIND_RECEIVE = 2'd3;

   localparam logic [3:0] ST_BOUND       = 4'd0;
   localparam logic [3:0] ST_TABLE_FULL  = 4'd1;
   localparam logic [3:0] ST_UNBOUND     = 4'd2;
   localparam logic [3:0] ST_ENQUEUED    = 4'd3;
   localparam logic [3:0] ST_DROP_FULL   = 4'd4;
   localparam logic [3:0] ST_DROP_NOPORT = 4'd5;
   localparam logic [3:0] ST_DEQUEUED    = 4'd6;
   localparam logic [3:0] ST_NOT_BOUND   = 4'd7;
   localparam logic [3:0] ST_EMPTY       = 4'd8;
   localparam logic [3:0] ST_FREED       = 4'd9;

   localparam logic [1:0] SEL_ZERO   = 2'd0;
   localparam logic [1:0] SEL_REQ    = 2'd1;
   localparam logic [1:0] SEL_STORE  = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       slot_inc;
      logic       load_ptr;
      logic       bind_wr;
      logic       clr_slot;
      logic       enq_wr;
      logic       head_adv;
      logic       emit;
      logic [3:0] emit_status;
      logic [1:0] emit_sel;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       match;
      logic       slot_last;
      logic       empty;
      logic       full;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

/* hdl/udpq_if.sv */
// Request and response channel interfaces.
`default_nettype none
interface udpq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] port;
   logic [15:0] handle;
   modport source (output valid, output kind, output port, output handle, input ready);
   modport sink   (input valid, input kind, input port, input handle, output ready);
endinterface

interface udpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [15:0] handle_out;
   logic        last;
   modport source (output valid, output status, output handle_out, output last, input ready);
   modport sink   (input valid, input status, input handle_out, input last, output ready);
endinterface
`default_nettype wire

/* hdl/udp_port_demux_queues_core.sv */
// Top level: UDP port demultiplexer with per-socket ring queues.
//
//   channel   dir  fields                      handshake
//   req_chan  in   kind, port, handle          valid/ready
//   rsp_chan  out  status, handle_out, last    valid/ready
//
// One request at a time. Slot lookup scans the port table one slot at a
// time, each slot taking a table read and a compare, until the matching
// slot or the last slot; a dequeue adds a ring store read before its emit.
// Unbind adds a ring store read and an emit per freed handle.
// Reset is synchronous and clears control state, the response valid flag and slot-bound flags only.
// A stalled response holds the sequencer in its emit state.
`default_nettype none
module udp_port_demux_queues_core
   import udpq_pkg::*;
#(
   parameter int SOCKET_SLOTS = 32,
   parameter int RING_DEPTH   = 16,
   parameter int HANDLE_BITS  = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   udpq_req_if.sink   req_chan,
   udpq_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   udpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   udpq_dp #(
      .SOCKET_SLOTS (SOCKET_SLOTS),
      .RING_DEPTH   (RING_DEPTH),
      .HANDLE_BITS  (HANDLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_chan.kind),
      .req_port       (req_chan.port),
      .req_handle     (req_chan.handle),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_status     (rsp_chan.status),
      .rsp_handle_out (rsp_chan.handle_out),
      .rsp_last       (rsp_chan.last),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
`default_nettype wire

/* hdl/udpq_ctrl.sv */
// Controller: sequences slot scan, ring access and response emission.
`default_nettype none
module udpq_ctrl
   import udpq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_ACT  = 3'd4;
   localparam logic [2:0] S_FREE = 3'd5;
   localparam logic [2:0] S_DEQ  = 3'd6;
   localparam logic [2:0] S_MISS = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_RD;
            end
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            priority if (stat.match) begin
               state_in = S_LOAD;
            end else if (stat.slot_last) begin
               state_in = S_MISS;
            end else begin
               cmd.slot_inc = 1'b1;
               state_in     = S_RD;
            end
         end
         S_LOAD: begin
            cmd.load_ptr = 1'b1;
            state_in     = S_ACT;
         end
         S_ACT: begin
            if (stat.out_free) begin
               cmd.emit_last = 1'b1;
               unique case (stat.kind)
                  KIND_BIND: begin
                     cmd.bind_wr     = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_BOUND;
                     state_in        = S_IDLE;
                  end
                  KIND_UNBIND: begin
                     if (stat.empty) begin
                        cmd.clr_slot    = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_UNBOUND;
                        state_in        = S_IDLE;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  KIND_DELIVER: begin
                     cmd.emit = 1'b1;
                     if (stat.full) begin
                        cmd.emit_status = ST_DROP_FULL;
                        cmd.emit_sel    = SEL_REQ;
                     end else begin
                        cmd.enq_wr      = 1'b1;
                        cmd.emit_status = ST_ENQUEUED;
                     end
                     state_in = S_IDLE;
                  end
                  default: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                        state_in        = S_IDLE;
                     end else begin
                        state_in = S_DEQ;
                     end
                  end
               endcase
            end
         end
         S_FREE: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_FREED;
               cmd.emit_sel    = SEL_STORE;
               cmd.head_adv    = 1'b1;
               state_in        = S_ACT;
            end
         end
         S_DEQ: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_DEQUEUED;
               cmd.emit_sel    = SEL_STORE;
               cmd.emit_last   = 1'b1;
               cmd.head_adv    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               unique case (stat.kind)
                  KIND_BIND:    cmd.emit_status = ST_TABLE_FULL;
                  KIND_UNBIND:  cmd.emit_status = ST_UNBOUND;
                  KIND_DELIVER: begin
                     cmd.emit_status = ST_DROP_NOPORT;
                     cmd.emit_sel    = SEL_REQ;
                  end
                  default:      cmd.emit_status = ST_NOT_BOUND;
               endcase
               state_in = S_IDLE;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/udpq_dp.sv */
// Datapath: slot port table, ring pointers, handle store and response register.
`default_nettype none
module udpq_dp
   import udpq_pkg::*;
#(
   parameter int SOCKET_SLOTS = 32,
   parameter int RING_DEPTH   = 16,
   parameter int HANDLE_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_port,
   input  wire logic [15:0] req_handle,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [3:0]       rsp_status,
   output logic [15:0]      rsp_handle_out,
   output logic             rsp_last,
   input  wire cmd_type     cmd,
   output stat_type         stat
);

   localparam int SW = (SOCKET_SLOTS > 1) ? $clog2(SOCKET_SLOTS) : 1;
   localparam int PW = $clog2(RING_DEPTH);
   localparam int STORE_DEPTH = SOCKET_SLOTS * RING_DEPTH;
   localparam int AW = $clog2(STORE_DEPTH);

   logic [15:0]            port_mem  [SOCKET_SLOTS];
   logic [PW-1:0]          head_mem  [SOCKET_SLOTS];
   logic [PW-1:0]          tail_mem  [SOCKET_SLOTS];
   logic [HANDLE_BITS-1:0] store_mem [STORE_DEPTH];

   logic [SOCKET_SLOTS-1:0] written_ff;
   logic [1:0]              kind_ff;
   logic [15:0]             key_ff;
   logic [15:0]             req_port_ff;
   logic [HANDLE_BITS-1:0]  handle_ff;
   logic [SW-1:0]           slot_ff;
   logic [PW-1:0]           head_ff, tail_ff;
   logic [15:0]             port_rd_ff;
   logic [PW-1:0]           head_rd_ff, tail_rd_ff;
   logic [HANDLE_BITS-1:0]  store_rd_ff;
   logic                    rsp_valid_ff;
   logic [3:0]              rsp_status_ff;
   logic [15:0]             rsp_handle_ff;
   logic                    rsp_last_ff;

   logic [31:0]            hin32;
   logic [31:0]            hst32;
   logic [31:0]            hrq32;
   logic [15:0]            eff_port;
   logic [AW-1:0]          store_addr;
   logic [PW-1:0]          head_nx, tail_nx;
   logic [15:0]            emit_handle;

   assign hin32      = 32'(req_handle);
   assign hst32      = 32'(store_rd_ff);
   assign hrq32      = 32'(handle_ff);
   assign eff_port   = written_ff[slot_ff] ? port_rd_ff : 16'd0;
   assign store_addr = AW'(slot_ff) * AW'(RING_DEPTH) + AW'(head_ff);
   assign head_nx    = (head_ff == PW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_nx    = (tail_ff == PW'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      stat.kind      = kind_ff;
      stat.match     = (eff_port == key_ff) && ((kind_ff == KIND_BIND) || (key_ff != 16'd0));
      stat.slot_last = (slot_ff == SW'(SOCKET_SLOTS - 1));
      stat.empty     = (head_ff == tail_ff);
      stat.full      = (tail_nx == head_ff);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      unique case (cmd.emit_sel)
         SEL_REQ:   emit_handle = hrq32[15:0];
         SEL_STORE: emit_handle = hst32[15:0];
         default:   emit_handle = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.bind_wr) begin
            written_ff[slot_ff] <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= req_kind;
         key_ff    <= (req_kind == KIND_BIND) ? 16'd0 : req_port;
         handle_ff <= hin32[HANDLE_BITS-1:0];
         slot_ff   <= '0;
      end else if (cmd.slot_inc) begin
         slot_ff <= slot_ff + 1'b1;
      end
      if (cmd.load_ptr) begin
         head_ff <= head_rd_ff;
         tail_ff <= tail_rd_ff;
      end else if (cmd.head_adv) begin
         head_ff <= head_nx;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_handle_ff <= emit_handle;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bind_wr) begin
         port_mem[slot_ff] <= req_port_ff;
      end else if (cmd.clr_slot) begin
         port_mem[slot_ff] <= 16'd0;
      end
      port_rd_ff <= port_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_port_ff <= req_port;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bind_wr) begin
         head_mem[slot_ff] <= '0;
      end else if (cmd.head_adv) begin
         head_mem[slot_ff] <= head_nx;
      end
      head_rd_ff <= head_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.bind_wr) begin
         tail_mem[slot_ff] <= '0;
      end else if (cmd.enq_wr) begin
         tail_mem[slot_ff] <= tail_nx;
      end
      tail_rd_ff <= tail_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.enq_wr) begin
         store_mem[AW'(slot_ff) * AW'(RING_DEPTH) + AW'(tail_ff)] <= handle_ff;
      end
      store_rd_ff <= store_mem[store_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire
